### rtl/hsi2rgb_pkg.sv
// Shared types, constants and helpers for the HSI to RGB converter pipeline.
// No dependencies.
`default_nettype none

package hsi2rgb_pkg;

	localparam int unsigned CH_W         = 17;
	localparam logic [CH_W-1:0] ONE_Q16  = 17'd65536;
	localparam int unsigned HALF_Q16     = 32768;
	localparam int unsigned HALF_SQRT3   = 56756;

	localparam int unsigned CORDIC_STEPS = 16;
	localparam int unsigned CW           = 33;
	localparam int unsigned ZW           = 25;
	localparam logic signed [CW-1:0] CORDIC_START = 33'sd1073741824;
	localparam logic signed [ZW-1:0] DEG60_Q16    = 25'sd3932160;

	localparam logic signed [ZW-1:0] ATAN_DEG_Q16 [CORDIC_STEPS] = '{
		25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
		25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
		25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
		25'sd917,     25'sd458,     25'sd229,    25'sd115
	};

	localparam int unsigned DEN_W     = 32;
	localparam int unsigned NUM_W     = 48;
	localparam int unsigned QUOT_BITS = 18;
	localparam int unsigned Q_W       = 20;

	localparam int unsigned MIX_STAGES   = 5;
	localparam int unsigned PIPE_LATENCY = 1 + CORDIC_STEPS + 1 + QUOT_BITS + 1 + MIX_STAGES;

	typedef enum logic [1:0] {
		SECTOR_RG = 2'd0,
		SECTOR_GB = 2'd1,
		SECTOR_BR = 2'd2
	} sector_t;

	typedef struct packed {
		sector_t         sector;
		logic [CH_W-1:0] sat;
		logic [CH_W-1:0] inten;
	} side_t;

	// arithmetic shift right that rounds toward zero
	function automatic logic signed [CW-1:0] shr_trunc(input logic signed [CW-1:0] v,
		input int unsigned k);
		logic signed [CW-1:0] sh;
		logic [CW-1:0] mask;
		sh   = v >>> k;
		mask = ~({CW{1'b1}} << k);
		if (v[CW-1] && ((v & mask) != '0)) begin
			sh = sh + {{(CW-1){1'b0}}, 1'b1};
		end
		return sh;
	endfunction

endpackage

`default_nettype wire

### rtl/hsi2rgb_cordic.sv
// Front stage (sector split, angle bin, input clamps) and the CORDIC rotation pipeline.
// Depends on hsi2rgb_pkg.
`default_nettype none

module hsi2rgb_cordic import hsi2rgb_pkg::*; #(
	parameter int unsigned ANGLE_TABLE_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [15:0]          hue,
	input  logic [CH_W-1:0]      saturation,
	input  logic [CH_W-1:0]      intensity,
	output logic                 out_valid,
	output side_t                out_side,
	output logic signed [CW-1:0] out_x,
	output logic signed [CW-1:0] out_y
);

	localparam int unsigned FRAC_BITS = 16 - ANGLE_TABLE_BITS;
	localparam logic [15:0] BIN_MASK  = 16'({16{1'b1}} << FRAC_BITS);

	logic [17:0]          pos3;
	logic [15:0]          bin_pos;
	logic signed [ZW-1:0] z_in;
	logic [CH_W-1:0]      sat_c;
	logic [CH_W-1:0]      inten_c;

	logic                 v_s    [0:CORDIC_STEPS];
	side_t                side_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] x_s    [0:CORDIC_STEPS];
	logic signed [CW-1:0] y_s    [0:CORDIC_STEPS];
	logic signed [ZW-1:0] z_s    [0:CORDIC_STEPS];

	always_comb begin
		pos3    = {2'b00, hue} + {1'b0, hue, 1'b0};
		bin_pos = pos3[15:0] & BIN_MASK;
		// bin * 120 degrees, minus 60 degrees
		z_in    = {2'b00, bin_pos, 7'b0} - {6'b0, bin_pos, 3'b0} - DEG60_Q16;
		sat_c   = (saturation > ONE_Q16) ? ONE_Q16 : saturation;
		inten_c = (intensity > ONE_Q16) ? ONE_Q16 : intensity;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]           <= CORDIC_START;
		y_s[0]           <= '0;
		z_s[0]           <= z_in;
		side_s[0].sector <= sector_t'(pos3[17:16]);
		side_s[0].sat    <= sat_c;
		side_s[0].inten  <= inten_c;
	end

	genvar k;
	for (k = 0; k < CORDIC_STEPS; k++) begin : g_step
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;

		assign dx = shr_trunc(y_s[k], k);
		assign dy = shr_trunc(x_s[k], k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			side_s[k+1] <= side_s[k];
			if (!z_s[k][ZW-1]) begin
				x_s[k+1] <= x_s[k] - dx;
				y_s[k+1] <= y_s[k] + dy;
				z_s[k+1] <= z_s[k] - ATAN_DEG_Q16[k];
			end else begin
				x_s[k+1] <= x_s[k] + dx;
				y_s[k+1] <= y_s[k] - dy;
				z_s[k+1] <= z_s[k] + ATAN_DEG_Q16[k];
			end
		end
	end

	assign out_valid = v_s[CORDIC_STEPS];
	assign out_side  = side_s[CORDIC_STEPS];
	assign out_x     = x_s[CORDIC_STEPS];
	assign out_y     = y_s[CORDIC_STEPS];

endmodule

`default_nettype wire

### rtl/hsi2rgb_divider.sv
// Ratio q = 1/2 - (sqrt3/2) * y / x: one multiply stage, a radix-2 restoring
// divider with one quotient bit per stage, and a final sign/offset stage. Uses hsi2rgb_pkg.
`default_nettype none

module hsi2rgb_divider import hsi2rgb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  side_t                 in_side,
	input  logic signed [CW-1:0]  in_x,
	input  logic signed [CW-1:0]  in_y,
	output logic                  out_valid,
	output side_t                 out_side,
	output logic signed [Q_W-1:0] out_q
);

	localparam int unsigned TW = DEN_W + QUOT_BITS;

	logic [DEN_W-1:0] den_c;
	logic [DEN_W-1:0] ymag_c;
	logic [NUM_W-1:0] num_c;

	logic                 v_s    [0:QUOT_BITS];
	side_t                side_s [0:QUOT_BITS];
	logic                 neg_s  [0:QUOT_BITS];
	logic [NUM_W-1:0]     rem_s  [0:QUOT_BITS];
	logic [DEN_W-1:0]     den_s  [0:QUOT_BITS];
	logic [QUOT_BITS-1:0] quot_s [0:QUOT_BITS];

	logic                  v_q;
	side_t                 side_q;
	logic signed [Q_W-1:0] q_q;

	always_comb begin
		den_c  = (in_x[CW-1] || (in_x == '0)) ? DEN_W'(1) : in_x[DEN_W-1:0];
		ymag_c = in_y[CW-1] ? DEN_W'(-in_y) : in_y[DEN_W-1:0];
		num_c  = NUM_W'(ymag_c) * NUM_W'(HALF_SQRT3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= in_side;
		neg_s[0]  <= in_y[CW-1];
		rem_s[0]  <= num_c;
		den_s[0]  <= den_c;
		quot_s[0] <= '0;
	end

	genvar t;
	for (t = 0; t < QUOT_BITS; t++) begin : g_div
		localparam int unsigned J = QUOT_BITS - 1 - t;
		logic [TW-1:0] trial;
		logic          take;

		assign trial = TW'(den_s[t]) << J;
		assign take  = TW'(rem_s[t]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[t+1] <= 1'b0;
			end else begin
				v_s[t+1] <= v_s[t];
			end
		end

		always_ff @(posedge clk) begin
			side_s[t+1] <= side_s[t];
			neg_s[t+1]  <= neg_s[t];
			den_s[t+1]  <= den_s[t];
			rem_s[t+1]  <= take ? (rem_s[t] - trial[NUM_W-1:0]) : rem_s[t];
			quot_s[t+1] <= quot_s[t] | (QUOT_BITS'(take) << J);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_s[QUOT_BITS];
		end
	end

	always_ff @(posedge clk) begin
		side_q <= side_s[QUOT_BITS];
		if (neg_s[QUOT_BITS]) begin
			q_q <= Q_W'(HALF_Q16) + Q_W'(quot_s[QUOT_BITS]);
		end else begin
			q_q <= Q_W'(HALF_Q16) - Q_W'(quot_s[QUOT_BITS]);
		end
	end

	assign out_valid = v_q;
	assign out_side  = side_q;
	assign out_q     = q_q;

endmodule

`default_nettype wire

### rtl/hsi2rgb_mix.sv
// Channel mixing: saturation products, sector routing, intensity scaling,
// saturation to 1.0 and the lamp decision. Uses hsi2rgb_pkg.
`default_nettype none

module hsi2rgb_mix import hsi2rgb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  side_t                 in_side,
	input  logic signed [Q_W-1:0] in_q,
	output logic                  out_valid,
	output logic [CH_W-1:0]       red,
	output logic [CH_W-1:0]       green,
	output logic [CH_W-1:0]       blue,
	output logic                  lamp_on
);

	localparam int unsigned PW    = 39;
	localparam int unsigned CHW   = 18;
	localparam int unsigned PRD_W = CHW + CH_W;
	localparam int unsigned SUM_W = CH_W + 2;
	localparam logic [SUM_W-1:0] LAMP_LIMIT = 19'd98304;

	// channel = 1 + p/65536 (truncating), clamped at zero
	function automatic logic [CHW-1:0] chan_of(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = p >>> 16;
		if (p[PW-1] && (p[15:0] != '0)) begin
			t = t + PW'(1);
		end
		t = t + PW'(65536);
		return t[PW-1] ? '0 : t[CHW-1:0];
	endfunction

	function automatic logic [CH_W-1:0] scale_sat(input logic [PRD_W-1:0] p);
		logic [PRD_W-17:0] v;
		v = p[PRD_W-1:16];
		return (v > (PRD_W-16)'(ONE_Q16)) ? ONE_Q16 : v[CH_W-1:0];
	endfunction

	logic signed [17:0]    s_sg;
	logic signed [Q_W:0]   qf_c;
	logic signed [PW-1:0]  pdom_c;
	logic signed [PW-1:0]  pfol_c;
	logic [CHW-1:0]        dom_c;
	logic [CHW-1:0]        fol_c;
	logic [CHW-1:0]        con_c;
	logic [CHW-1:0]        chr_c;
	logic [CHW-1:0]        chg_c;
	logic [CHW-1:0]        chb_c;
	logic [SUM_W-1:0]      sum_c;

	logic                  v_s1;
	side_t                 side_s1;
	logic signed [PW-1:0]  pdom_s1;
	logic signed [PW-1:0]  pfol_s1;

	logic                  v_s2;
	logic [CH_W-1:0]       inten_s2;
	logic [CHW-1:0]        chr_s2;
	logic [CHW-1:0]        chg_s2;
	logic [CHW-1:0]        chb_s2;

	logic                  v_s3;
	logic [PRD_W-1:0]      pr_s3;
	logic [PRD_W-1:0]      pg_s3;
	logic [PRD_W-1:0]      pb_s3;

	logic                  v_s4;
	logic [CH_W-1:0]       r_s4;
	logic [CH_W-1:0]       g_s4;
	logic [CH_W-1:0]       b_s4;

	always_comb begin
		s_sg   = {1'b0, in_side.sat};
		qf_c   = 21'sd65536 - (Q_W+1)'(in_q);
		pdom_c = PW'(s_sg) * PW'(in_q);
		pfol_c = PW'(s_sg) * PW'(qf_c);
	end

	always_comb begin
		dom_c = chan_of(pdom_s1);
		fol_c = chan_of(pfol_s1);
		con_c = CHW'(ONE_Q16) - CHW'(side_s1.sat);
		case (side_s1.sector)
			SECTOR_RG: begin
				chr_c = dom_c;
				chg_c = fol_c;
				chb_c = con_c;
			end
			SECTOR_GB: begin
				chr_c = con_c;
				chg_c = dom_c;
				chb_c = fol_c;
			end
			SECTOR_BR: begin
				chr_c = fol_c;
				chg_c = con_c;
				chb_c = dom_c;
			end
			default: begin
				chr_c = '0;
				chg_c = '0;
				chb_c = '0;
			end
		endcase
	end

	assign sum_c = SUM_W'(r_s4) + SUM_W'(g_s4) + SUM_W'(b_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_s1  <= in_side;
		pdom_s1  <= pdom_c;
		pfol_s1  <= pfol_c;

		inten_s2 <= side_s1.inten;
		chr_s2   <= chr_c;
		chg_s2   <= chg_c;
		chb_s2   <= chb_c;

		pr_s3    <= PRD_W'(chr_s2) * PRD_W'(inten_s2);
		pg_s3    <= PRD_W'(chg_s2) * PRD_W'(inten_s2);
		pb_s3    <= PRD_W'(chb_s2) * PRD_W'(inten_s2);

		r_s4     <= scale_sat(pr_s3);
		g_s4     <= scale_sat(pg_s3);
		b_s4     <= scale_sat(pb_s3);

		red      <= r_s4;
		green    <= g_s4;
		blue     <= b_s4;
		lamp_on  <= sum_c > LAMP_LIMIT;
	end

endmodule

`default_nettype wire

### rtl/hsi_to_rgb_converter_top.sv
// HSI to RGB converter, top level: cordic front end, divider, channel mix.
// Path from an accepted start to its done strobe: front stage, 16 CORDIC stages,
// multiply and 18-stage restoring divider, mix pipeline. Throughput: one item per cycle.
// busy stays low; each result shows for one cycle with done and cannot be held off.
// arst_n clears all valid bits at once; data registers are not reset.
`default_nettype none

module hsi_to_rgb_converter_top import hsi2rgb_pkg::*; #(
	parameter int unsigned ANGLE_TABLE_BITS = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [15:0]     hue,
	input  logic [CH_W-1:0] saturation,
	input  logic [CH_W-1:0] intensity,
	output logic            done,
	output logic [CH_W-1:0] red,
	output logic [CH_W-1:0] green,
	output logic [CH_W-1:0] blue,
	output logic            lamp_on
);

	logic                  accept;
	logic                  cor_valid;
	side_t                 cor_side;
	logic signed [CW-1:0]  cor_x;
	logic signed [CW-1:0]  cor_y;
	logic                  div_valid;
	side_t                 div_side;
	logic signed [Q_W-1:0] div_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	hsi2rgb_cordic #(
		.ANGLE_TABLE_BITS(ANGLE_TABLE_BITS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.hue       (hue),
		.saturation(saturation),
		.intensity (intensity),
		.out_valid (cor_valid),
		.out_side  (cor_side),
		.out_x     (cor_x),
		.out_y     (cor_y)
	);

	hsi2rgb_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cor_valid),
		.in_side  (cor_side),
		.in_x     (cor_x),
		.in_y     (cor_y),
		.out_valid(div_valid),
		.out_side (div_side),
		.out_q    (div_q)
	);

	hsi2rgb_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_valid),
		.in_side  (div_side),
		.in_q     (div_q),
		.out_valid(done),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.lamp_on  (lamp_on)
	);

	a_item_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##PIPE_LATENCY done)
		else $error("accepted item did not complete on time");

	a_no_extra_done: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |-> ##PIPE_LATENCY !done)
		else $error("done without a matching accepted item");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (red <= ONE_Q16) && (green <= ONE_Q16) && (blue <= ONE_Q16))
		else $error("channel above full scale");

endmodule

`default_nettype wire
